@@ hdl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// No dependencies; every other file in the block imports this package.
package rau_pkg;

    localparam int FIELD_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_NUM_W       = 32;
    localparam int OUT_DEN_W       = 31;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_MUL = 4'd2,
        ACT_DIV = 4'd3,
        ACT_NEG = 4'd4,
        ACT_LT  = 4'd5,
        ACT_LE  = 4'd6,
        ACT_EQ  = 4'd7,
        ACT_NE  = 4'd8,
        ACT_GT  = 4'd9,
        ACT_GE  = 4'd10
    } action_t;

    // Classification of one request, passed from the front end to the back end.
    typedef struct packed {
        logic arith;
        logic cmp;
        logic dz;
        logic neg;
    } rau_flags_t;

endpackage

@@ hdl/rau_front.sv @@
// Front end: accepts requests, forms the cross products and classifies them.
// Depends on rau_pkg.
module rau_front #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [3:0]                    action,
    input  logic signed [FIELD_WIDTH-1:0] first_num,
    input  logic [FIELD_WIDTH-2:0]        first_den,
    input  logic signed [FIELD_WIDTH-1:0] second_num,
    input  logic [FIELD_WIDTH-2:0]        second_den,
    output logic                          q_push,
    input  logic                          q_full,
    output rau_pkg::rau_flags_t           q_flags,
    output logic [2*FIELD_WIDTH-1:0]      q_mn,
    output logic [2*FIELD_WIDTH-1:0]      q_md
);
    import rau_pkg::*;

    localparam int W  = FIELD_WIDTH;
    localparam int MW = 2 * FIELD_WIDTH;

    logic                  v_reg;
    logic [3:0]            act_reg;
    logic signed [2*W-2:0] left_reg;
    logic signed [2*W-2:0] right_reg;
    logic signed [2*W-1:0] nn_reg;
    logic [2*W-3:0]        dd_reg;
    logic signed [W-1:0]   n1_reg;
    logic [W-2:0]          d1_reg;

    logic                  take;
    logic signed [MW-1:0]  rn;
    logic signed [MW-1:0]  rd;
    rau_flags_t            flags;

    assign full   = v_reg && q_full;
    assign take   = push && !full;
    assign q_push = v_reg && !q_full;

    // The stage register holds the four products of one request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (take)
        begin
            v_reg <= 1'b1;
        end
        else if (q_push)
        begin
            v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg   <= action;
            left_reg  <= first_num * signed'({1'b0, second_den});
            right_reg <= signed'({1'b0, first_den}) * second_num;
            nn_reg    <= MW'(first_num) * MW'(second_num);
            dd_reg    <= first_den * second_den;
            n1_reg    <= first_num;
            d1_reg    <= first_den;
        end
    end

    always_comb
    begin
        rn          = '0;
        rd          = MW'(1);
        flags.arith = 1'b1;
        flags.cmp   = 1'b0;
        case (act_reg)
            ACT_ADD:
            begin
                rn = MW'(left_reg) + MW'(right_reg);
                rd = signed'(MW'(dd_reg));
            end
            ACT_SUB:
            begin
                rn = MW'(left_reg) - MW'(right_reg);
                rd = signed'(MW'(dd_reg));
            end
            ACT_MUL:
            begin
                rn = MW'(nn_reg);
                rd = signed'(MW'(dd_reg));
            end
            ACT_DIV:
            begin
                rn = MW'(left_reg);
                rd = MW'(right_reg);
            end
            ACT_NEG:
            begin
                rn = -MW'(n1_reg);
                rd = signed'(MW'(d1_reg));
            end
            ACT_LT:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg < right_reg;
            end
            ACT_LE:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg <= right_reg;
            end
            ACT_EQ:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg == right_reg;
            end
            ACT_NE:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg != right_reg;
            end
            ACT_GT:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg > right_reg;
            end
            ACT_GE:
            begin
                flags.arith = 1'b0;
                flags.cmp   = left_reg >= right_reg;
            end
            default:
            begin
                flags.arith = 1'b0;
            end
        endcase
        q_mn      = rn[MW-1] ? MW'(-rn) : MW'(rn);
        q_md      = rd[MW-1] ? MW'(-rd) : MW'(rd);
        flags.dz  = flags.arith && (rd == '0);
        flags.neg = rn[MW-1] ^ rd[MW-1];
        q_flags   = flags;
    end

endmodule

@@ hdl/rau_queue.sv @@
// Short queue between the front end and the back end.
// Depends on rau_pkg for its depth.
module rau_queue #(
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [DATA_W-1:0] wdata,
    output logic              q_full,
    input  logic              rd,
    output logic [DATA_W-1:0] rdata,
    output logic              q_empty
);
    import rau_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     rp_reg;
    logic [CW-1:0]     cnt_reg;

    assign q_full  = cnt_reg == CW'(QUEUE_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign rdata   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/rau_back.sv @@
// Back end: binary gcd, one restoring divider used twice and the result register.
// Depends on rau_pkg.
module rau_back #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  rau_pkg::rau_flags_t               q_flags,
    input  logic [2*FIELD_WIDTH-1:0]          q_mn,
    input  logic [2*FIELD_WIDTH-1:0]          q_md,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rau_pkg::OUT_NUM_W-1:0] result_num,
    output logic [rau_pkg::OUT_DEN_W-1:0]     result_den,
    output logic                              compare_true,
    output logic                              div_by_zero
);
    import rau_pkg::*;

    localparam int MW = 2 * FIELD_WIDTH;
    localparam int KW = $clog2(MW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [MW-1:0]        a_reg;
    logic [MW-1:0]        b_reg;
    logic [KW-1:0]        k_reg;
    logic [MW-1:0]        mn_reg;
    logic [MW-1:0]        md_reg;
    logic                 neg_reg;
    logic [MW-1:0]        g_reg;
    logic [MW-1:0]        q_reg;
    logic [MW-1:0]        rem_reg;
    logic [MW-1:0]        qn_reg;
    logic [KW-1:0]        cnt_reg;
    logic [OUT_NUM_W-1:0] res_num_reg;
    logic [OUT_DEN_W-1:0] res_den_reg;
    logic                 res_cmp_reg;
    logic                 res_dz_reg;
    logic                 out_valid_reg;
    logic [OUT_NUM_W-1:0] out_num_reg;
    logic [OUT_DEN_W-1:0] out_den_reg;
    logic                 out_cmp_reg;
    logic                 out_dz_reg;

    logic [MW:0]          rem_sh;
    logic                 ge;
    logic [MW-1:0]        q_step;
    logic [MW-1:0]        rem_step;
    logic                 last;
    logic signed [MW:0]   num_s;
    logic [63:0]          num64;
    logic [63:0]          den64;
    logic                 load_out;

    assign q_pop        = (state_reg == S_IDLE) && !q_empty;
    assign empty        = !out_valid_reg;
    assign result_num   = signed'(out_num_reg);
    assign result_den   = out_den_reg;
    assign compare_true = out_cmp_reg;
    assign div_by_zero  = out_dz_reg;

    // A finished result moves to the output register once that register is free.
    assign load_out     = (state_reg == S_DONE) && (!out_valid_reg || pop);

    // One quotient bit per cycle.
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[MW-1]};
        ge       = rem_sh >= {1'b0, g_reg};
        q_step   = {q_reg[MW-2:0], ge};
        rem_step = ge ? MW'(rem_sh - {1'b0, g_reg}) : rem_sh[MW-1:0];
        last     = cnt_reg == KW'(MW - 1);
        num_s    = (neg_reg && (qn_reg != '0)) ? -signed'({1'b0, qn_reg})
                                               : signed'({1'b0, qn_reg});
        num64    = 64'(num_s);
        den64    = 64'(q_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (!q_flags.arith || q_flags.dz)
                        begin
                            res_num_reg <= '0;
                            res_den_reg <= OUT_DEN_W'(1);
                            res_cmp_reg <= q_flags.cmp;
                            res_dz_reg  <= q_flags.dz;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            a_reg       <= q_mn;
                            b_reg       <= q_md;
                            mn_reg      <= q_mn;
                            md_reg      <= q_md;
                            neg_reg     <= q_flags.neg;
                            k_reg       <= '0;
                            res_cmp_reg <= 1'b0;
                            res_dz_reg  <= 1'b0;
                            state_reg   <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    if (a_reg == '0 || b_reg == '0)
                    begin
                        g_reg     <= (a_reg == '0) ? (b_reg << k_reg) : (a_reg << k_reg);
                        q_reg     <= mn_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVN;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    else if (a_reg >= b_reg)
                    begin
                        a_reg <= a_reg - b_reg;
                    end
                    else
                    begin
                        b_reg <= b_reg - a_reg;
                    end
                end
                S_DIVN:
                begin
                    if (last)
                    begin
                        qn_reg    <= q_step;
                        q_reg     <= md_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVD;
                    end
                    else
                    begin
                        q_reg   <= q_step;
                        rem_reg <= rem_step;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIVD:
                begin
                    if (last)
                    begin
                        res_num_reg <= num64[OUT_NUM_W-1:0];
                        res_den_reg <= den64[OUT_DEN_W-1:0];
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        q_reg   <= q_step;
                        rem_reg <= rem_step;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        out_num_reg   <= res_num_reg;
                        out_den_reg   <= res_den_reg;
                        out_cmp_reg   <= res_cmp_reg;
                        out_dz_reg    <= res_dz_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: front end, queue and back end.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
// Both sides look like a queue. A request is taken at a rising edge with
// push high and full low; it carries an action code and two fractions.
// A result is shown while empty is low and leaves at an edge with pop high.
// Every request gives exactly one result, in request order.
// The front end registers the four cross products, then classifies the
// request from that register and writes it into a two-entry queue once the
// queue has room. The back end reduces arithmetic results with a binary gcd,
// one subtract or shift per cycle, then divides numerator and denominator by
// the gcd with one shared restoring divider, one quotient bit per cycle. The
// back end works on one request at a time. A finished result waits in the
// output register; while the receiver stalls, the back end may finish one
// more result and the front end keeps filling the queue, and only then is
// full raised. Reset clears all control state and empties the block; no
// clearing pass is needed.
module rational_arithmetic_unit #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [3:0]                            action,
    input  logic signed [FIELD_WIDTH-1:0]         first_num,
    input  logic [FIELD_WIDTH-2:0]                first_den,
    input  logic signed [FIELD_WIDTH-1:0]         second_num,
    input  logic [FIELD_WIDTH-2:0]                second_den,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [rau_pkg::OUT_NUM_W-1:0]  result_num,
    output logic [rau_pkg::OUT_DEN_W-1:0]         result_den,
    output logic                                  compare_true,
    output logic                                  div_by_zero
);
    import rau_pkg::*;

    localparam int MW = 2 * FIELD_WIDTH;
    localparam int QW = $bits(rau_flags_t) + 2 * MW;

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    rau_flags_t      f_flags;
    logic [MW-1:0]   f_mn;
    logic [MW-1:0]   f_md;
    logic [QW-1:0]   q_rdata;
    rau_flags_t      b_flags;
    logic [MW-1:0]   b_mn;
    logic [MW-1:0]   b_md;

    assign {b_flags, b_mn, b_md} = q_rdata;

    rau_front #(.FIELD_WIDTH(FIELD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .first_num  (first_num),
        .first_den  (first_den),
        .second_num (second_num),
        .second_den (second_den),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_flags    (f_flags),
        .q_mn       (f_mn),
        .q_md       (f_md)
    );

    rau_queue #(.DATA_W(QW)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wdata   ({f_flags, f_mn, f_md}),
        .q_full  (q_full),
        .rd      (q_pop),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    rau_back #(.FIELD_WIDTH(FIELD_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_flags      (b_flags),
        .q_mn         (b_mn),
        .q_md         (b_md),
        .empty        (empty),
        .pop          (pop),
        .result_num   (result_num),
        .result_den   (result_den),
        .compare_true (compare_true),
        .div_by_zero  (div_by_zero)
    );

    // A division by zero always presents the fraction 0/1.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && div_by_zero) |-> (result_num == '0 && result_den == OUT_DEN_W'(1)))
        else $error("division by zero result is not 0/1");

    // A comparison never raises the division flag.
    a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && compare_true) |-> !div_by_zero)
        else $error("comparison result carries division flag");

    // The input side stalls only when the internal queue is full.
    a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("full raised while queue has room");

    // The back end never reads from an empty queue.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

endmodule
